### sv/lrutsc_pkg.sv
// Package for the tagged slot cache with least-recently-used replacement.
// Holds the action codes and the fixed field widths. No dependencies.
package lrutsc_pkg;

    localparam int ACT_W  = 2;
    localparam int KEY_W  = 32;
    localparam int SIZE_W = 16;
    localparam int NUM_W  = 16;
    localparam int CNT_W  = 15;
    localparam int STAT_W = 32;

    localparam logic [ACT_W-1:0] ACT_LOOKUP     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_STORE      = 2'd1;
    localparam logic [ACT_W-1:0] ACT_INVALIDATE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR_STAT = 2'd3;

endpackage

### sv/lru_tagged_slot_cache_unit.sv
// Fully associative tag store with use-stamp LRU replacement, top level.
// Depends on lrutsc_pkg for action codes and field widths.
//
// Each transaction takes one request and returns one result, and the unit holds one
// transaction at a time, so a result that waits holds off the next request. Lookups and
// stores scan every slot through a single read port of the slot memory, one slot per
// cycle; the result is registered and presented after the scan and a decide step.
// Invalidate, statistics clear and rejected stores present their result in the cycle
// after acceptance. The slot memory needs no clearing pass after reset because per-slot
// valid bits gate every read.
// The reported slot index addresses an external payload memory.
module lru_tagged_slot_cache_unit #(
    parameter int SLOTS      = 16,
    parameter int STAMP_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [lrutsc_pkg::ACT_W-1:0]         i_action,
    input  logic [lrutsc_pkg::KEY_W-1:0]         i_tag_key,
    input  logic [lrutsc_pkg::SIZE_W-1:0]        i_element_size,
    input  logic signed [lrutsc_pkg::NUM_W-1:0]  i_item_total,
    input  logic signed [lrutsc_pkg::NUM_W-1:0]  i_room,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_ok,
    output logic [$clog2(SLOTS)-1:0]             o_slot,
    output logic [lrutsc_pkg::CNT_W-1:0]         o_stored_count,
    output logic                                 o_evicted,
    output logic [$clog2(SLOTS+1)-1:0]           o_ready_slots,
    output logic [lrutsc_pkg::STAT_W-1:0]        o_hit_total,
    output logic [lrutsc_pkg::STAT_W-1:0]        o_miss_total,
    output logic [lrutsc_pkg::STAT_W-1:0]        o_store_total,
    output logic [lrutsc_pkg::STAT_W-1:0]        o_eviction_total
);
    import lrutsc_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int NV_W   = $clog2(SLOTS + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;
    localparam logic [1:0] S_OUT    = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]      key;
        logic [SIZE_W-1:0]     size;
        logic [CNT_W-1:0]      count;
        logic [STAMP_BITS-1:0] stamp;
    } t_entry;

    t_entry r_mem [SLOTS];
    t_entry r_rdata;
    logic   r_rvld;

    logic [1:0]            r_state, n_state;
    logic [SLOTS-1:0]      r_vbits, n_vbits;
    logic [NV_W-1:0]       r_nvalid, n_nvalid;
    logic [STAMP_BITS-1:0] r_stamp, n_stamp;
    logic [STAT_W-1:0]     r_hits, n_hits, r_misses, n_misses;
    logic [STAT_W-1:0]     r_stores, n_stores, r_evicts, n_evicts;

    logic [ACT_W-1:0]      r_act, n_act;
    logic [KEY_W-1:0]      r_key, n_key;
    logic [SIZE_W-1:0]     r_size, n_size;
    logic [CNT_W-1:0]      r_total, n_total;
    logic [NUM_W-1:0]      r_room, n_room;

    logic [SLOT_W-1:0]     r_addr, n_addr;
    logic                  r_issue, n_issue;
    logic                  r_dvld, n_dvld;
    logic [SLOT_W-1:0]     r_didx, n_didx;

    logic                  r_fnd, n_fnd;
    logic [SLOT_W-1:0]     r_fidx, n_fidx;
    logic [CNT_W-1:0]      r_fcnt, n_fcnt;
    logic                  r_emp, n_emp;
    logic [SLOT_W-1:0]     r_eidx, n_eidx;
    logic                  r_ohave, n_ohave;
    logic [SLOT_W-1:0]     r_oidx, n_oidx;
    logic [STAMP_BITS-1:0] r_ostamp, n_ostamp;

    logic                  r_ok, n_ok;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_evicted, n_evicted;

    logic                  mem_we;
    logic [SLOT_W-1:0]     mem_waddr;
    t_entry                mem_wdata;

    logic                  hit;
    logic [STAMP_BITS-1:0] stamp_inc;
    logic [STAMP_BITS-1:0] stamp_next;
    logic [SLOT_W-1:0]     tgt;

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = (r_state == S_OUT);
    assign o_ok             = r_ok;
    assign o_slot           = r_slot;
    assign o_stored_count   = r_cnt;
    assign o_evicted        = r_evicted;
    assign o_ready_slots    = r_nvalid;
    assign o_hit_total      = r_hits;
    assign o_miss_total     = r_misses;
    assign o_store_total    = r_stores;
    assign o_eviction_total = r_evicts;

    assign hit        = r_fnd && !r_room[NUM_W-1] && (r_fcnt <= r_room[CNT_W-1:0]);
    assign stamp_inc  = r_stamp + 1'b1;
    assign stamp_next = (stamp_inc == '0) ? {{(STAMP_BITS-1){1'b0}}, 1'b1} : stamp_inc;
    assign tgt        = r_fnd ? r_fidx : (r_emp ? r_eidx : r_oidx);

    always_comb begin
        n_state   = r_state;
        n_vbits   = r_vbits;
        n_nvalid  = r_nvalid;
        n_stamp   = r_stamp;
        n_hits    = r_hits;
        n_misses  = r_misses;
        n_stores  = r_stores;
        n_evicts  = r_evicts;
        n_act     = r_act;
        n_key     = r_key;
        n_size    = r_size;
        n_total   = r_total;
        n_room    = r_room;
        n_addr    = r_addr;
        n_issue   = 1'b0;
        n_dvld    = 1'b0;
        n_didx    = r_addr;
        n_fnd     = r_fnd;
        n_fidx    = r_fidx;
        n_fcnt    = r_fcnt;
        n_emp     = r_emp;
        n_eidx    = r_eidx;
        n_ohave   = r_ohave;
        n_oidx    = r_oidx;
        n_ostamp  = r_ostamp;
        n_ok      = r_ok;
        n_slot    = r_slot;
        n_cnt     = r_cnt;
        n_evicted = r_evicted;
        mem_we    = 1'b0;
        mem_waddr = tgt;
        mem_wdata = '{key: r_key, size: r_size, count: r_total, stamp: stamp_next};

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_act     = i_action;
                    n_key     = i_tag_key;
                    n_size    = i_element_size;
                    n_total   = i_item_total[CNT_W-1:0];
                    n_room    = i_room;
                    n_ok      = 1'b0;
                    n_slot    = '0;
                    n_cnt     = '0;
                    n_evicted = 1'b0;
                    n_fnd     = 1'b0;
                    n_emp     = 1'b0;
                    n_ohave   = 1'b0;
                    n_addr    = '0;
                    n_state   = S_OUT;
                    unique case (i_action)
                        ACT_LOOKUP: begin
                            n_issue = 1'b1;
                            n_state = S_SCAN;
                        end
                        ACT_STORE: begin
                            if (i_element_size != '0 && !i_item_total[NUM_W-1]) begin
                                n_issue = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        ACT_INVALIDATE: begin
                            n_vbits  = '0;
                            n_nvalid = '0;
                            n_stamp  = '0;
                            n_ok     = 1'b1;
                        end
                        default: begin
                            n_hits   = '0;
                            n_misses = '0;
                            n_stores = '0;
                            n_evicts = '0;
                            n_ok     = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_dvld = r_issue;
                if (r_issue) begin
                    if (r_addr == SLOT_W'(SLOTS - 1)) begin
                        n_issue = 1'b0;
                    end else begin
                        n_issue = 1'b1;
                        n_addr  = r_addr + 1'b1;
                    end
                end
                if (r_dvld) begin
                    if (r_rvld && !r_fnd && r_rdata.key == r_key && r_rdata.size == r_size) begin
                        n_fnd  = 1'b1;
                        n_fidx = r_didx;
                        n_fcnt = r_rdata.count;
                    end
                    if (!r_rvld && !r_emp) begin
                        n_emp  = 1'b1;
                        n_eidx = r_didx;
                    end
                    if (r_rvld && (!r_ohave || r_rdata.stamp < r_ostamp)) begin
                        n_ohave  = 1'b1;
                        n_oidx   = r_didx;
                        n_ostamp = r_rdata.stamp;
                    end
                    if (r_didx == SLOT_W'(SLOTS - 1)) begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                n_state = S_OUT;
                if (r_act == ACT_LOOKUP) begin
                    if (hit) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_fidx;
                        mem_wdata = '{key: r_key, size: r_size, count: r_fcnt,
                                      stamp: stamp_next};
                        n_stamp   = stamp_next;
                        n_hits    = r_hits + 1'b1;
                        n_ok      = 1'b1;
                        n_slot    = r_fidx;
                        n_cnt     = r_fcnt;
                    end else begin
                        n_misses = r_misses + 1'b1;
                    end
                end else begin
                    mem_we   = 1'b1;
                    n_stamp  = stamp_next;
                    n_stores = r_stores + 1'b1;
                    n_ok     = 1'b1;
                    n_slot   = tgt;
                    n_vbits[tgt] = 1'b1;
                    if (!r_vbits[tgt]) begin
                        n_nvalid = r_nvalid + 1'b1;
                    end
                    if (!r_fnd && !r_emp) begin
                        n_evicted = 1'b1;
                        n_evicts  = r_evicts + 1'b1;
                    end
                end
            end
            default: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[r_addr];
        r_rvld  <= r_vbits[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vbits  <= '0;
            r_nvalid <= '0;
            r_stamp  <= '0;
            r_hits   <= '0;
            r_misses <= '0;
            r_stores <= '0;
            r_evicts <= '0;
            r_issue  <= 1'b0;
            r_dvld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_vbits  <= n_vbits;
            r_nvalid <= n_nvalid;
            r_stamp  <= n_stamp;
            r_hits   <= n_hits;
            r_misses <= n_misses;
            r_stores <= n_stores;
            r_evicts <= n_evicts;
            r_issue  <= n_issue;
            r_dvld   <= n_dvld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act     <= n_act;
        r_key     <= n_key;
        r_size    <= n_size;
        r_total   <= n_total;
        r_room    <= n_room;
        r_addr    <= n_addr;
        r_didx    <= n_didx;
        r_fnd     <= n_fnd;
        r_fidx    <= n_fidx;
        r_fcnt    <= n_fcnt;
        r_emp     <= n_emp;
        r_eidx    <= n_eidx;
        r_ohave   <= n_ohave;
        r_oidx    <= n_oidx;
        r_ostamp  <= n_ostamp;
        r_ok      <= n_ok;
        r_slot    <= n_slot;
        r_cnt     <= n_cnt;
        r_evicted <= n_evicted;
    end

`ifndef SYNTHESIS
    a_nvalid_matches_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_nvalid) == $countones(r_vbits))
        else $error("valid slot count disagrees with valid bits");

    a_no_accept_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("request accepted while a result is pending");

    a_evict_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_evicted) |-> (o_ok && r_nvalid == NV_W'(SLOTS)))
        else $error("eviction reported without a full accepted store");

    a_count_only_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stored_count != '0) |-> (o_ok && r_act == ACT_LOOKUP))
        else $error("stored count reported without a lookup hit");

    a_stamp_nonzero_after_touch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && (r_act == ACT_STORE || hit)) |=> (r_stamp != '0))
        else $error("use stamp landed on zero");
`endif

endmodule

### sim/lru_tagged_slot_cache_unit_tb.sv
// Testbench for lru_tagged_slot_cache_unit: directed and random cache transactions
// against an in-bench predictor, with random idling on both handshakes.
// Depends on lrutsc_pkg and the lru_tagged_slot_cache_unit RTL.
`timescale 1ns / 100ps

module lru_tagged_slot_cache_unit_tb;
    import lrutsc_pkg::*;

    localparam int NUM_LINES    = 16;
    localparam int RANDOM_REQS  = 1424;
    localparam int HOLD_AT      = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 3000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic [KEY_W-1:0]         tag_key;
        logic [SIZE_W-1:0]        element_size;
        logic signed [NUM_W-1:0]  item_total;
        logic signed [NUM_W-1:0]  room;
        logic                     drain_first;
    } t_cache_req;

    typedef struct packed {
        logic               ok;
        logic [3:0]         slot;
        logic [CNT_W-1:0]   stored_count;
        logic               evicted;
        logic [4:0]         ready_slots;
        logic [STAT_W-1:0]  hit_total;
        logic [STAT_W-1:0]  miss_total;
        logic [STAT_W-1:0]  store_total;
        logic [STAT_W-1:0]  eviction_total;
    } t_cache_rsp;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [ACT_W-1:0]         i_action = ACT_LOOKUP;
    logic [KEY_W-1:0]         i_tag_key = '0;
    logic [SIZE_W-1:0]        i_element_size = '0;
    logic signed [NUM_W-1:0]  i_item_total = '0;
    logic signed [NUM_W-1:0]  i_room = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic                     o_ok;
    logic [3:0]               o_slot;
    logic [CNT_W-1:0]         o_stored_count;
    logic                     o_evicted;
    logic [4:0]               o_ready_slots;
    logic [STAT_W-1:0]        o_hit_total;
    logic [STAT_W-1:0]        o_miss_total;
    logic [STAT_W-1:0]        o_store_total;
    logic [STAT_W-1:0]        o_eviction_total;

    lru_tagged_slot_cache_unit #(
        .SLOTS      (NUM_LINES),
        .STAMP_BITS (32)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_tag_key        (i_tag_key),
        .i_element_size   (i_element_size),
        .i_item_total     (i_item_total),
        .i_room           (i_room),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_ok             (o_ok),
        .o_slot           (o_slot),
        .o_stored_count   (o_stored_count),
        .o_evicted        (o_evicted),
        .o_ready_slots    (o_ready_slots),
        .o_hit_total      (o_hit_total),
        .o_miss_total     (o_miss_total),
        .o_store_total    (o_store_total),
        .o_eviction_total (o_eviction_total)
    );

    logic              line_used  [NUM_LINES];
    logic [KEY_W-1:0]  line_key   [NUM_LINES];
    logic [SIZE_W-1:0] line_bytes [NUM_LINES];
    logic [CNT_W-1:0]  line_items [NUM_LINES];
    logic [31:0]       line_age   [NUM_LINES];
    logic [31:0]       age_clock;
    logic [STAT_W-1:0] exp_hits;
    logic [STAT_W-1:0] exp_misses;
    logic [STAT_W-1:0] exp_stores;
    logic [STAT_W-1:0] exp_evicts;

    t_cache_req  req_backlog_q[$];
    t_cache_rsp  predicted_rsp_q[$];
    logic [KEY_W-1:0] key_pool [24];
    logic        mismatch_seen = 1'b0;
    int          idle_left = 0;
    int          stall_left = 0;
    int          sent_count = 0;
    int          checked_count = 0;
    int          quiet_cycles = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic void touch_line(int idx);
        age_clock = age_clock + 1;
        if (age_clock == 0)
            age_clock = 1;
        line_age[idx] = age_clock;
    endfunction

    function automatic t_cache_rsp cache_model_step(t_cache_req rq);
        t_cache_rsp rs;
        int hit_line;
        int i;
        rs = '0;
        hit_line = -1;
        for (i = 0; i < NUM_LINES; i++) begin
            if (hit_line < 0 && line_used[i] && line_key[i] == rq.tag_key &&
                line_bytes[i] == rq.element_size)
                hit_line = i;
        end
        case (rq.action)
            ACT_LOOKUP: begin
                if (hit_line >= 0 && !rq.room[NUM_W-1] &&
                    line_items[hit_line] <= rq.room[CNT_W-1:0]) begin
                    rs.ok = 1'b1;
                    rs.slot = hit_line[3:0];
                    rs.stored_count = line_items[hit_line];
                    touch_line(hit_line);
                    exp_hits = exp_hits + 1;
                end else begin
                    exp_misses = exp_misses + 1;
                end
            end
            ACT_STORE: begin
                if (rq.element_size != 0 && !rq.item_total[NUM_W-1]) begin
                    if (hit_line < 0) begin
                        for (i = 0; i < NUM_LINES; i++) begin
                            if (hit_line < 0 && !line_used[i])
                                hit_line = i;
                        end
                    end
                    if (hit_line < 0) begin
                        hit_line = 0;
                        for (i = 1; i < NUM_LINES; i++) begin
                            if (line_age[i] < line_age[hit_line])
                                hit_line = i;
                        end
                        rs.evicted = 1'b1;
                        exp_evicts = exp_evicts + 1;
                    end
                    line_key[hit_line] = rq.tag_key;
                    line_bytes[hit_line] = rq.element_size;
                    line_items[hit_line] = rq.item_total[CNT_W-1:0];
                    line_used[hit_line] = 1'b1;
                    touch_line(hit_line);
                    exp_stores = exp_stores + 1;
                    rs.ok = 1'b1;
                    rs.slot = hit_line[3:0];
                end
            end
            ACT_INVALIDATE: begin
                for (i = 0; i < NUM_LINES; i++)
                    line_used[i] = 1'b0;
                age_clock = '0;
                rs.ok = 1'b1;
            end
            default: begin
                exp_hits = '0;
                exp_misses = '0;
                exp_stores = '0;
                exp_evicts = '0;
                rs.ok = 1'b1;
            end
        endcase
        for (i = 0; i < NUM_LINES; i++)
            rs.ready_slots = rs.ready_slots + {4'd0, line_used[i]};
        rs.hit_total = exp_hits;
        rs.miss_total = exp_misses;
        rs.store_total = exp_stores;
        rs.eviction_total = exp_evicts;
        return rs;
    endfunction

    function automatic t_cache_req mk_req(logic [ACT_W-1:0] act, logic [KEY_W-1:0] key,
                                          logic [SIZE_W-1:0] size,
                                          logic signed [NUM_W-1:0] total,
                                          logic signed [NUM_W-1:0] cap);
        t_cache_req rq;
        rq.action = act;
        rq.tag_key = key;
        rq.element_size = size;
        rq.item_total = total;
        rq.room = cap;
        rq.drain_first = 1'b0;
        return rq;
    endfunction

    function automatic t_cache_req rand_request();
        t_cache_req rq;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            rq.action = ACT_INVALIDATE;
        else if (pick < 4)
            rq.action = ACT_CLEAR_STAT;
        else if (pick < 48)
            rq.action = ACT_STORE;
        else
            rq.action = ACT_LOOKUP;
        if ($urandom_range(0, 99) < 12)
            rq.tag_key = $urandom;
        else
            rq.tag_key = key_pool[$urandom_range(0, 23)];
        pick = $urandom_range(0, 99);
        if (pick < 10)
            rq.element_size = SIZE_W'($urandom);
        else if (pick < 13)
            rq.element_size = '0;
        else
            rq.element_size = 16'd1 << (2 * $urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 55)
            rq.item_total = NUM_W'($urandom_range(0, 120));
        else if (pick < 85)
            rq.item_total = NUM_W'($urandom_range(0, 32767));
        else
            rq.item_total = NUM_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 50)
            rq.room = NUM_W'($urandom_range(0, 150));
        else if (pick < 80)
            rq.room = NUM_W'($urandom_range(0, 32767));
        else
            rq.room = NUM_W'($urandom);
        rq.drain_first = 1'b0;
        return rq;
    endfunction

    function automatic int draw_idle(int n, int span);
        if ((n / span) % 4 == 3)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    task automatic check_field(string what, logic [STAT_W-1:0] want, logic [STAT_W-1:0] got);
        if (want !== got) begin
            $display("%0t %s mismatch: expected %0h, actual %0h", $time, what, want, got);
            mismatch_seen = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin : drive_proc
        t_cache_req nxt;
        t_cache_req sent;
        logic took;
        int left;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            idle_left <= 0;
        end else begin
            took = i_in_valid && o_in_ready;
            left = idle_left;
            if (took) begin
                sent = mk_req(i_action, i_tag_key, i_element_size, i_item_total, i_room);
                predicted_rsp_q.push_back(cache_model_step(sent));
                sent_count = sent_count + 1;
                left = draw_idle(sent_count, 53);
            end else if (!i_in_valid && left != 0) begin
                left = left - 1;
            end
            if (i_in_valid && !took) begin
                i_in_valid <= 1'b1;
            end else if (left == 0 && req_backlog_q.size() != 0 &&
                         (!req_backlog_q[0].drain_first || predicted_rsp_q.size() == 0)) begin
                nxt = req_backlog_q.pop_front();
                i_action <= nxt.action;
                i_tag_key <= nxt.tag_key;
                i_element_size <= nxt.element_size;
                i_item_total <= nxt.item_total;
                i_room <= nxt.room;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
            idle_left <= left;
        end
    end

    always @(posedge i_clk) begin : observe_proc
        t_cache_rsp want;
        int stall;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left <= 0;
        end else begin
            stall = stall_left;
            if (o_out_valid && i_out_ready) begin
                if (predicted_rsp_q.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual ok=%0b slot=%0d",
                             $time, o_ok, o_slot);
                    mismatch_seen = 1'b1;
                end else begin
                    want = predicted_rsp_q.pop_front();
                    check_field("ok", STAT_W'(want.ok), STAT_W'(o_ok));
                    check_field("slot", STAT_W'(want.slot), STAT_W'(o_slot));
                    check_field("stored_count", STAT_W'(want.stored_count),
                                STAT_W'(o_stored_count));
                    check_field("evicted", STAT_W'(want.evicted), STAT_W'(o_evicted));
                    check_field("ready_slots", STAT_W'(want.ready_slots),
                                STAT_W'(o_ready_slots));
                    check_field("hit_total", want.hit_total, o_hit_total);
                    check_field("miss_total", want.miss_total, o_miss_total);
                    check_field("store_total", want.store_total, o_store_total);
                    check_field("eviction_total", want.eviction_total, o_eviction_total);
                end
                checked_count = checked_count + 1;
                if (checked_count == HOLD_AT)
                    stall = HOLD_CYCLES;
                else
                    stall = draw_idle(checked_count, 71);
            end else if (stall != 0) begin
                stall = stall - 1;
            end
            stall_left <= stall;
            i_out_ready <= (stall == 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[lru_tagged_slot_cache_unit] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus_proc
        t_cache_req rq;
        int k;
        for (k = 0; k < NUM_LINES; k++) begin
            line_used[k] = 1'b0;
            line_key[k] = '0;
            line_bytes[k] = '0;
            line_items[k] = '0;
            line_age[k] = '0;
        end
        age_clock = '0;
        exp_hits = '0;
        exp_misses = '0;
        exp_stores = '0;
        exp_evicts = '0;
        for (k = 0; k < 24; k++)
            key_pool[k] = $urandom;

        req_backlog_q.push_back(mk_req(ACT_LOOKUP, '0, '0, '0, '0));
        req_backlog_q.push_back(mk_req(ACT_STORE, 32'h1234_5678, '0, 16'sd5, 16'sd5));
        req_backlog_q.push_back(mk_req(ACT_STORE, 32'h1234_5678, 16'd8, 16'sh8000, '0));
        req_backlog_q.push_back(mk_req(ACT_STORE, '1, '1, 16'sh7FFF, '0));
        req_backlog_q.push_back(mk_req(ACT_LOOKUP, '1, '1, '0, 16'sh7FFF));
        req_backlog_q.push_back(mk_req(ACT_LOOKUP, '1, '1, '0, 16'sh7FFE));
        req_backlog_q.push_back(mk_req(ACT_LOOKUP, '1, '1, '0, 16'sh8000));
        req_backlog_q.push_back(mk_req(ACT_STORE, '1, '1, '0, '1));
        req_backlog_q.push_back(mk_req(ACT_LOOKUP, '1, '1, '0, '0));
        // Sixteen new keys fill the remaining slots and the last one evicts the oldest.
        for (k = 1; k <= NUM_LINES; k++)
            req_backlog_q.push_back(mk_req(ACT_STORE, KEY_W'(k), 16'd1, NUM_W'(k), '0));
        req_backlog_q.push_back(mk_req(ACT_INVALIDATE, '0, '0, '0, '0));
        req_backlog_q.push_back(mk_req(ACT_CLEAR_STAT, '1, '1, '1, '1));

        for (k = 0; k < RANDOM_REQS; k++) begin
            rq = rand_request();
            rq.drain_first = (k % 300 == 0);
            req_backlog_q.push_back(rq);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(posedge i_clk);
        while (req_backlog_q.size() != 0 || i_in_valid || predicted_rsp_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (!mismatch_seen && predicted_rsp_q.size() == 0)
            $display("[lru_tagged_slot_cache_unit] OK");
        else
            $display("[lru_tagged_slot_cache_unit] ERROR");
        $finish;
    end

endmodule
